// ===== src/bfe_pkg.sv =====
// Shared types and field kind codes for the binary field extractor.
package bfe_pkg;

  localparam logic [3:0] KIND_U8     = 4'd0;
  localparam logic [3:0] KIND_BOOL   = 4'd1;
  localparam logic [3:0] KIND_U16    = 4'd2;
  localparam logic [3:0] KIND_S16    = 4'd3;
  localparam logic [3:0] KIND_U24    = 4'd4;
  localparam logic [3:0] KIND_U32    = 4'd5;
  localparam logic [3:0] KIND_S32    = 4'd6;
  localparam logic [3:0] KIND_U64    = 4'd7;
  localparam logic [3:0] KIND_S32_BE = 4'd8;
  localparam logic [3:0] KIND_UVAR32 = 4'd9;
  localparam logic [3:0] KIND_UVAR64 = 4'd10;
  localparam logic [3:0] KIND_ZZ32   = 4'd11;
  localparam logic [3:0] KIND_ZZ64   = 4'd12;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [3:0] field_kind;
    logic       last_byte;
  } src_item_t;

  typedef struct packed {
    logic [63:0] field_value;
    logic [3:0]  value_kind;
    logic        overflow;
  } res_item_t;

endpackage

// ===== src/binary_field_extractor_top.sv =====
// Byte-serial field extractor: fixed-width integers and LEB128 varints.
//
// Usage:
//   src channel (src_valid/src_ready/src_data) takes one buffer byte per
//   request, with the field kind sampled on the first byte of each field and
//   last_byte marking the end of the buffer.
//   res channel (res_valid/res_ready/res_data) gives one decoded value per
//   completed field, or an overflow result when a varint runs too long or
//   the buffer ends mid-field; bytes after an overflow are dropped up to
//   the end of the buffer.
// Timing:
//   One byte is taken per cycle while src_ready is high. A result is registered
//   from the byte that completes its field; the byte decode is a single pass from
//   the field state registers to the result register.
//   A one-entry skid register catches a result while res is stalled, so
//   src stays ready with one result waiting; src_ready falls only while
//   both the result and skid registers are full.
// Reset:
//   rst (synchronous) clears the field state and empties both result
//   registers; the next byte starts a new field.
module binary_field_extractor_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                src_valid,
  output logic                src_ready,
  input  bfe_pkg::src_item_t  src_data,
  output logic                res_valid,
  input  logic                res_ready,
  output bfe_pkg::res_item_t  res_data
);

  localparam logic [3:0] VAR32_MAX_BYTES = 4'd5;
  localparam logic [3:0] VAR64_MAX_BYTES = 4'd10;

  logic [63:0] accumulator;
  logic [3:0]  bytes_taken;
  logic [3:0]  active_kind;
  logic        in_field;
  logic        dropping;

  logic                skid_valid;
  bfe_pkg::res_item_t  skid_data;

  logic        src_fire;
  logic [63:0] acc_base;
  logic [3:0]  cnt_base;
  logic [3:0]  kind_cur;
  logic        is_var;
  logic        is_var32;
  logic [5:0]  var_shift;
  logic [5:0]  fix_shift;
  logic [63:0] accumulator_next;
  logic [3:0]  bytes_taken_next;
  logic        done;
  logic        var_ovf;
  logic        res_ovf;
  logic        emit;
  bfe_pkg::res_item_t  res_new;

  function automatic logic [3:0] fixed_length(input logic [3:0] kind);
    logic [3:0] len;
    unique case (kind) inside
      bfe_pkg::KIND_U16, bfe_pkg::KIND_S16:                      len = 4'd2;
      bfe_pkg::KIND_U24:                                         len = 4'd3;
      bfe_pkg::KIND_U32, bfe_pkg::KIND_S32, bfe_pkg::KIND_S32_BE: len = 4'd4;
      bfe_pkg::KIND_U64:                                         len = 4'd8;
      default:                                                   len = 4'd1;
    endcase
    return len;
  endfunction

  function automatic logic [63:0] finish_value(input logic [3:0] kind,
                                               input logic [63:0] a);
    logic [63:0] v;
    logic [31:0] z;
    z = (a[31:0] >> 1) ^ {32{a[0]}};
    unique case (kind) inside
      bfe_pkg::KIND_BOOL:                        v = {63'd0, |a};
      bfe_pkg::KIND_U16:                         v = {48'd0, a[15:0]};
      bfe_pkg::KIND_S16:                         v = {{48{a[15]}}, a[15:0]};
      bfe_pkg::KIND_U24:                         v = {40'd0, a[23:0]};
      bfe_pkg::KIND_U32, bfe_pkg::KIND_UVAR32:   v = {32'd0, a[31:0]};
      bfe_pkg::KIND_S32, bfe_pkg::KIND_S32_BE:   v = {{32{a[31]}}, a[31:0]};
      bfe_pkg::KIND_U64, bfe_pkg::KIND_UVAR64:   v = a;
      bfe_pkg::KIND_ZZ32:                        v = {{32{z[31]}}, z};
      bfe_pkg::KIND_ZZ64:                        v = (a >> 1) ^ {64{a[0]}};
      default:                                   v = {56'd0, a[7:0]};
    endcase
    return v;
  endfunction

  assign src_ready = !skid_valid;
  assign src_fire  = src_valid && src_ready;

  assign acc_base = in_field ? accumulator : 64'd0;
  assign cnt_base = in_field ? bytes_taken : 4'd0;
  assign kind_cur = in_field ? active_kind : src_data.field_kind;

  assign is_var   = (kind_cur >= bfe_pkg::KIND_UVAR32) && (kind_cur <= bfe_pkg::KIND_ZZ64);
  assign is_var32 = (kind_cur == bfe_pkg::KIND_UVAR32) || (kind_cur == bfe_pkg::KIND_ZZ32);

  assign var_shift = 6'(7 * cnt_base);
  assign fix_shift = {cnt_base[2:0], 3'b000};

  always_comb begin
    accumulator_next = acc_base;
    bytes_taken_next = cnt_base;
    done             = 1'b0;
    var_ovf          = 1'b0;
    if (is_var) begin
      bytes_taken_next = cnt_base + 4'd1;
      if (cnt_base < VAR64_MAX_BYTES) begin
        accumulator_next = acc_base | ({57'd0, src_data.data_byte[6:0]} << var_shift);
      end
      if (src_data.data_byte[7]) begin
        var_ovf = is_var32 ? (bytes_taken_next >= VAR32_MAX_BYTES)
                           : (bytes_taken_next >= VAR64_MAX_BYTES);
      end else begin
        done = 1'b1;
      end
    end else begin
      bytes_taken_next = {1'b0, cnt_base[2:0]} + 4'd1;
      if (kind_cur == bfe_pkg::KIND_S32_BE) begin
        accumulator_next = {acc_base[55:0], src_data.data_byte};
      end else begin
        accumulator_next = acc_base | ({56'd0, src_data.data_byte} << fix_shift);
      end
      done = bytes_taken_next >= fixed_length(kind_cur);
    end
  end

  assign res_ovf = var_ovf || (!done && src_data.last_byte);
  assign emit    = src_fire && !dropping && (res_ovf || done);

  assign res_new.field_value = res_ovf ? 64'd0 : finish_value(kind_cur, accumulator_next);
  assign res_new.value_kind  = kind_cur;
  assign res_new.overflow    = res_ovf;

  // field state
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      bytes_taken <= '0;
      active_kind <= '0;
      in_field    <= 1'b0;
      dropping    <= 1'b0;
    end else if (src_fire) begin
      if (dropping) begin
        if (src_data.last_byte) begin
          dropping <= 1'b0;
        end
      end else if (res_ovf || done) begin
        accumulator <= '0;
        bytes_taken <= '0;
        active_kind <= src_data.last_byte ? 4'd0 : kind_cur;
        in_field    <= 1'b0;
        dropping    <= res_ovf && !src_data.last_byte;
      end else begin
        accumulator <= accumulator_next;
        bytes_taken <= bytes_taken_next;
        active_kind <= kind_cur;
        in_field    <= 1'b1;
      end
    end
  end

  // result register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (res_ready || !res_valid) begin
      if (skid_valid) begin
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        res_valid <= emit;
      end
    end else if (emit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready || !res_valid) begin
      if (skid_valid) begin
        res_data <= skid_data;
      end else if (emit) begin
        res_data <= res_new;
      end
    end else if (emit) begin
      skid_data <= res_new;
    end
  end

endmodule

// ===== src/bfe_checker.sv =====
// Port-level checks for the binary field extractor, bound to its top level.
module bfe_checker (
  input logic                clk,
  input logic                rst,
  input logic                src_valid,
  input logic                src_ready,
  input bfe_pkg::src_item_t  src_data,
  input logic                res_valid,
  input logic                res_ready,
  input bfe_pkg::res_item_t  res_data
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result dropped or changed while stalled");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !src_ready |-> res_valid && !$past(res_ready))
    else $error("src stalled without a waiting result");

  a_ovf_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.overflow |-> res_data.field_value == 64'd0)
    else $error("overflow result carries a value");

  a_bool_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.overflow && res_data.value_kind == bfe_pkg::KIND_BOOL
      |-> res_data.field_value[63:1] == 63'd0)
    else $error("bool result out of range");

  a_reset: assert property (@(posedge clk)
    rst |=> !res_valid && src_ready)
    else $error("reset left a result pending");

endmodule

bind binary_field_extractor_top bfe_checker u_bfe_checker (.*);
